// ----- hw/rtl/ftb_pkg.sv -----
package ftb_pkg;

  // byte transfer phases, one-hot
  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_WAIT_HIGH = 4'b0010,
    PH_SLOTS     = 4'b0100,
    PH_END_WAIT  = 4'b1000
  } phase_t;

  // completion status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ATN_ABORT = 2'd1,
    ST_TIMEOUT   = 2'd2
  } status_t;

  // input item kinds
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_START_TX = 2'd1;
  localparam logic [1:0] KIND_START_RX = 2'd2;
  localparam logic [1:0] KIND_NOP      = 2'd3;

  // plain order slot times in microseconds
  localparam logic [5:0] T_PLAIN_P0  = 6'd0;
  localparam logic [5:0] T_PLAIN_P1  = 6'd12;
  localparam logic [5:0] T_PLAIN_P2  = 6'd20;
  localparam logic [5:0] T_PLAIN_P3  = 6'd28;
  localparam logic [5:0] T_PLAIN_END = 6'd36;

  // inverted order slot times
  localparam logic [5:0] T_INV_P0  = 6'd0;
  localparam logic [5:0] T_INV_P1  = 6'd18;
  localparam logic [5:0] T_INV_P2  = 6'd28;
  localparam logic [5:0] T_INV_P3  = 6'd38;
  localparam logic [5:0] T_INV_END = 6'd48;

  // receive sample times
  localparam logic [5:0] T_RX_S0 = 6'd11;
  localparam logic [5:0] T_RX_S1 = 6'd21;
  localparam logic [5:0] T_RX_S2 = 6'd37;
  localparam logic [5:0] T_RX_S3 = 6'd47;

  // configuration
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

endpackage

// ----- hw/rtl/fastload_two_bit_byte_transfer_unit.sv -----
// result path: an accepted item lands in the input register, and its result is
//   captured in the result register when the item advances, which waits while a held result is not taken
// throughput: one item per cycle while no result is held or out_ready is high
// reset: synchronous active-low rst_n, phase idle, both lines released,
//   timeout_r back to 1000
module fastload_two_bit_byte_transfer_unit
  import ftb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_ar6_mode,
  input  logic        in_clk_level,
  input  logic        in_data_level,
  input  logic        in_atn_level,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_clk_release,
  output logic        out_data_release,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic [7:0]  out_rx_byte,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration register
  logic [15:0] timeout_r;

  // input register
  logic       in_valid_r;
  logic [1:0] kind_r;
  logic [7:0] tx_byte_r;
  logic       mode_in_r;
  logic       clk_lv_r;
  logic       data_lv_r;
  logic       atn_lv_r;

  // transfer state
  phase_t      phase_r, phase_nxt;
  logic [5:0]  slot_timer_r, slot_timer_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        mode_r, mode_nxt;
  logic        recv_r, recv_nxt;
  logic        clk_drv_r, clk_drv_nxt;
  logic        data_drv_r, data_drv_nxt;

  // result register
  logic        out_valid_r;
  logic        res_clk_r, res_data_r, res_busy_r, res_done_r;
  status_t     res_status_r;
  logic [7:0]  res_rx_r;

  logic        advance;
  logic        done_nxt;
  status_t     status_nxt;
  logic [7:0]  rx_nxt;
  logic        do_slot;
  logic        slot_end;
  logic [5:0]  t_slot;
  logic [15:0] wait_inc;

  // apb access
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      timeout_r <= pwdata[15:0];
    end
  end

  // handshake between the stages
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r    <= in_kind;
      tx_byte_r <= in_tx_byte;
      mode_in_r <= in_ar6_mode;
      clk_lv_r  <= in_clk_level;
      data_lv_r <= in_data_level;
      atn_lv_r  <= in_atn_level;
    end
  end

  // saturating end-handshake counter
  assign wait_inc = (wait_r != WAIT_MAX) ? wait_r + 16'd1 : wait_r;

  // phase update for one tick or start item, a NOP leaves the state alone
  always_comb begin
    phase_nxt      = phase_r;
    slot_timer_nxt = slot_timer_r;
    wait_nxt       = wait_r;
    shift_nxt      = shift_r;
    mode_nxt       = mode_r;
    recv_nxt       = recv_r;
    clk_drv_nxt    = clk_drv_r;
    data_drv_nxt   = data_drv_r;
    done_nxt       = 1'b0;
    status_nxt     = ST_OK;
    rx_nxt         = 8'd0;
    do_slot        = 1'b0;
    slot_end       = 1'b0;
    t_slot         = slot_timer_r;

    if (kind_r != KIND_NOP) begin
      if (phase_r == PH_IDLE &&
          (kind_r == KIND_START_TX || kind_r == KIND_START_RX)) begin
        recv_nxt = (kind_r == KIND_START_RX);
        if (kind_r == KIND_START_TX) begin
          mode_nxt  = mode_in_r;
          shift_nxt = mode_in_r ? tx_byte_r : ~tx_byte_r;
        end else begin
          shift_nxt = 8'd0;
        end
        clk_drv_nxt    = 1'b1;
        slot_timer_nxt = 6'd0;
        wait_nxt       = 16'd0;
        phase_nxt      = PH_WAIT_HIGH;
      end else if (phase_r == PH_WAIT_HIGH) begin
        if (!atn_lv_r) begin
          phase_nxt  = PH_IDLE;
          done_nxt   = 1'b1;
          status_nxt = ST_ATN_ABORT;
        end else if (data_lv_r) begin
          slot_timer_nxt = 6'd0;
          phase_nxt      = PH_SLOTS;
          t_slot         = 6'd0;
          do_slot        = 1'b1;
        end
      end else if (phase_r == PH_SLOTS) begin
        t_slot         = slot_timer_r + 6'd1;
        slot_timer_nxt = t_slot;
        do_slot        = 1'b1;
      end else if (phase_r == PH_END_WAIT) begin
        if (!atn_lv_r) begin
          phase_nxt  = PH_IDLE;
          done_nxt   = 1'b1;
          status_nxt = ST_ATN_ABORT;
        end else if (!data_lv_r) begin
          phase_nxt  = PH_IDLE;
          done_nxt   = 1'b1;
          status_nxt = ST_OK;
          if (recv_r) begin
            rx_nxt = shift_r;
          end
        end else begin
          wait_nxt = wait_inc;
          if (wait_inc >= timeout_r) begin
            phase_nxt  = PH_IDLE;
            done_nxt   = 1'b1;
            status_nxt = ST_TIMEOUT;
          end
        end
      end
    end

    // drive or sample the bit pair of the current slot
    if (do_slot) begin
      if (recv_r) begin
        if (t_slot == T_RX_S0) begin
          shift_nxt[7] = shift_r[7] | ~clk_lv_r;
          shift_nxt[5] = shift_r[5] | ~data_lv_r;
        end else if (t_slot == T_RX_S1) begin
          shift_nxt[6] = shift_r[6] | ~clk_lv_r;
          shift_nxt[4] = shift_r[4] | ~data_lv_r;
        end else if (t_slot == T_RX_S2) begin
          shift_nxt[3] = shift_r[3] | ~clk_lv_r;
          shift_nxt[1] = shift_r[1] | ~data_lv_r;
        end else if (t_slot == T_RX_S3) begin
          shift_nxt[2] = shift_r[2] | ~clk_lv_r;
          shift_nxt[0] = shift_r[0] | ~data_lv_r;
          clk_drv_nxt  = 1'b0;
          slot_end     = 1'b1;
        end
      end else if (mode_r) begin
        if (t_slot == T_PLAIN_P0) begin
          clk_drv_nxt  = shift_r[0];
          data_drv_nxt = shift_r[1];
        end else if (t_slot == T_PLAIN_P1) begin
          clk_drv_nxt  = shift_r[2];
          data_drv_nxt = shift_r[3];
        end else if (t_slot == T_PLAIN_P2) begin
          clk_drv_nxt  = shift_r[4];
          data_drv_nxt = shift_r[5];
        end else if (t_slot == T_PLAIN_P3) begin
          clk_drv_nxt  = shift_r[6];
          data_drv_nxt = shift_r[7];
        end else if (t_slot == T_PLAIN_END) begin
          clk_drv_nxt  = 1'b0;
          data_drv_nxt = 1'b1;
          slot_end     = 1'b1;
        end
      end else begin
        if (t_slot == T_INV_P0) begin
          clk_drv_nxt  = shift_r[7];
          data_drv_nxt = shift_r[5];
        end else if (t_slot == T_INV_P1) begin
          clk_drv_nxt  = shift_r[6];
          data_drv_nxt = shift_r[4];
        end else if (t_slot == T_INV_P2) begin
          clk_drv_nxt  = shift_r[3];
          data_drv_nxt = shift_r[1];
        end else if (t_slot == T_INV_P3) begin
          clk_drv_nxt  = shift_r[2];
          data_drv_nxt = shift_r[0];
        end else if (t_slot == T_INV_END) begin
          clk_drv_nxt  = 1'b0;
          data_drv_nxt = 1'b1;
          slot_end     = 1'b1;
        end
      end
    end

    // slots over, start the end handshake
    if (slot_end) begin
      phase_nxt = PH_END_WAIT;
      wait_nxt  = 16'd0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      slot_timer_r <= 6'd0;
      wait_r       <= 16'd0;
      shift_r      <= 8'd0;
      mode_r       <= 1'b0;
      recv_r       <= 1'b0;
      clk_drv_r    <= 1'b1;
      data_drv_r   <= 1'b1;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      slot_timer_r <= slot_timer_nxt;
      wait_r       <= wait_nxt;
      shift_r      <= shift_nxt;
      mode_r       <= mode_nxt;
      recv_r       <= recv_nxt;
      clk_drv_r    <= clk_drv_nxt;
      data_drv_r   <= data_drv_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_clk_r    <= clk_drv_nxt;
      res_data_r   <= data_drv_nxt;
      res_busy_r   <= (phase_nxt != PH_IDLE);
      res_done_r   <= done_nxt;
      res_status_r <= status_nxt;
      res_rx_r     <= rx_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_clk_release  = res_clk_r;
  assign out_data_release = res_data_r;
  assign out_busy_res     = res_busy_r;
  assign out_done_res     = res_done_r;
  assign out_status       = res_status_r;
  assign out_rx_byte      = res_rx_r;

  // a finished transfer never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_done_r |-> !res_busy_r)
    else $error("done result still reports busy");

  // a nonzero status only comes with done
  a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_status_r != ST_OK) |-> res_done_r)
    else $error("status without done");

  // received data only shows on a clean finish
  a_rx_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_rx_r != 8'd0) |-> res_done_r && (res_status_r == ST_OK))
    else $error("received byte outside a clean finish");

  // slot timer never runs past the last slot
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SLOTS) |-> (slot_timer_r < T_INV_END))
    else $error("slot timer past end of byte");

endmodule
